// ===== src/substring_prefix_suffix_matcher_macros.svh =====
// ----------------------------------------------------------------------------
// substring_prefix_suffix_matcher macros
// assertion shorthands for the matcher, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef SUBSTRING_PREFIX_SUFFIX_MATCHER_MACROS_SVH
`define SUBSTRING_PREFIX_SUFFIX_MATCHER_MACROS_SVH

// same-cycle implication
`define SPSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/spsm_pkg.sv =====
// ----------------------------------------------------------------------------
// spsm_pkg
// shared types and constants of the substring, prefix and suffix matcher
// ----------------------------------------------------------------------------
package spsm_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int PAT_W       = 8 * MAX_PATTERN;
    localparam int LEN_W       = 4;
    localparam int CNT_W       = 4;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES  = 2'd0,
        CFG_PATTERN_LENGTH = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       has_byte;
        logic       end_of_text;
    } text_item_t;

    typedef struct packed {
        logic found_inside;
        logic begins_with;
        logic finishes_with;
        logic last_result;
    } match_result_t;

    typedef struct packed {
        logic [PAT_W-1:0] window;
        logic [CNT_W-1:0] bytes_seen;
        logic             found;
        logic             prefix_ok;
    } string_state_t;

    localparam string_state_t STRING_CLEAR = '{
        window:     '0,
        bytes_seen: '0,
        found:      1'b0,
        prefix_ok:  1'b1
    };

endpackage

// ===== src/spsm_match.sv =====
// ----------------------------------------------------------------------------
// spsm_match
// window update and pattern compare for one text request
// ----------------------------------------------------------------------------
module spsm_match (
    input  spsm_pkg::string_state_t          state,
    input  spsm_pkg::text_item_t             item,
    input  logic [spsm_pkg::PAT_W-1:0]       pattern_bytes,
    input  logic [spsm_pkg::LEN_W-1:0]       pattern_length,
    output spsm_pkg::string_state_t          state_next,
    output spsm_pkg::match_result_t          result
);
    import spsm_pkg::*;

    localparam int IDX_W = $clog2(MAX_PATTERN);

    logic [LEN_W-1:0]    plen;
    string_state_t       eff;
    logic [7:0]          pat_at_count;
    logic [PAT_W-1:0]    win_shift;
    logic [MAX_PATTERN-1:0] lane_ok;
    logic                win_match;
    logic                long_enough;

    always_comb
    begin
        if (pattern_length > LEN_W'(MAX_PATTERN))
        begin
            plen = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            plen = pattern_length;
        end
    end

    assign pat_at_count = pattern_bytes[8*state.bytes_seen[IDX_W-1:0] +: 8];
    assign win_shift    = {state.window[PAT_W-9:0], item.text_byte};

    // state after taking this request's byte, before the window compare
    always_comb
    begin
        eff = state;
        if (item.has_byte)
        begin
            eff.window = win_shift;
            if (state.bytes_seen < CNT_W'(plen) && item.text_byte != pat_at_count)
            begin
                eff.prefix_ok = 1'b0;
            end
            if (state.bytes_seen != '1)
            begin
                eff.bytes_seen = state.bytes_seen + CNT_W'(1);
            end
        end
    end

    // newest window byte k lines up with pattern byte plen-1-k
    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            logic [IDX_W-1:0] pidx;
            pidx = IDX_W'(plen - LEN_W'(1) - LEN_W'(k));
            lane_ok[k] = (LEN_W'(k) >= plen) ||
                         (eff.window[8*k +: 8] == pattern_bytes[8*pidx +: 8]);
        end
    end

    assign win_match   = &lane_ok;
    assign long_enough = eff.bytes_seen >= CNT_W'(plen);

    always_comb
    begin
        state_next = eff;
        if (item.has_byte && plen != '0 && long_enough && win_match)
        begin
            state_next.found = 1'b1;
        end

        result.found_inside  = (plen != '0) && state_next.found;
        result.begins_with   = long_enough && eff.prefix_ok;
        result.finishes_with = (plen == '0) || (long_enough && win_match);
        result.last_result   = 1'b1;

        if (item.end_of_text)
        begin
            state_next = STRING_CLEAR;
        end
    end

endmodule

// ===== src/substring_prefix_suffix_matcher.sv =====
// ----------------------------------------------------------------------------
// substring_prefix_suffix_matcher
// streams a text one byte per request and flags pattern inside, at start, at end
// ----------------------------------------------------------------------------
// One text byte is taken every clock. A request lands in an input register,
// the window shift and the eight-lane pattern compare run between that
// register and the result register, which takes the result when the request
// that ends the string leaves the input register. The string state is updated in the
// same cycle, so the next byte may follow straight away; the input side only
// holds off when an end-of-string request meets a result not yet taken.
// Configuration writes are always accepted and should be made between strings.
module substring_prefix_suffix_matcher (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              text_valid,
    output logic                              text_ready,
    input  spsm_pkg::text_item_t              text,
    output logic                              result_valid,
    input  logic                              result_ready,
    output spsm_pkg::match_result_t           result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [spsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spsm_pkg::PAT_W-1:0]        cfg_data
);
    import spsm_pkg::*;

    `include "substring_prefix_suffix_matcher_macros.svh"

    logic [PAT_W-1:0]  pattern_bytes_reg;
    logic [LEN_W-1:0]  pattern_length_reg;

    logic              in_valid_reg;
    text_item_t        in_reg;
    string_state_t     str_reg;
    string_state_t     str_next;
    logic              out_valid_reg;
    match_result_t     out_reg;
    match_result_t     res_next;
    logic              out_free;
    logic              stage_go;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PATTERN_BYTES:  pattern_bytes_reg  <= cfg_data;
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    spsm_match u_match (
        .state          (str_reg),
        .item           (in_reg),
        .pattern_bytes  (pattern_bytes_reg),
        .pattern_length (pattern_length_reg),
        .state_next     (str_next),
        .result         (res_next)
    );

    // only a string end needs room in the result register
    assign out_free   = !out_valid_reg || result_ready;
    assign stage_go   = in_valid_reg && (!in_reg.end_of_text || out_free);
    assign text_ready = !in_valid_reg || stage_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            str_reg       <= STRING_CLEAR;
        end
        else
        begin
            if (text_ready)
            begin
                in_valid_reg <= text_valid;
            end
            if (stage_go)
            begin
                str_reg <= str_next;
            end
            if (stage_go && in_reg.end_of_text)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_valid && text_ready)
        begin
            in_reg <= text;
        end
        if (stage_go && in_reg.end_of_text)
        begin
            out_reg <= res_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `SPSM_ASSERT_NOW(a_last_marked, out_valid_reg, out_reg.last_result, "result without last mark")
    `SPSM_ASSERT_NEXT(a_clear_after_end, stage_go && in_reg.end_of_text, str_reg == STRING_CLEAR, "string state not cleared after end")
    `SPSM_ASSERT_NEXT(a_count_moves, stage_go && in_reg.has_byte && !in_reg.end_of_text, str_reg.bytes_seen != '0, "byte taken but count still zero")
    `SPSM_ASSERT_NEXT(a_idle_holds, !stage_go, $stable(str_reg), "string state moved without a request")

endmodule
